FILE: design/sliding_window_sender_fast_retransmit_defines.svh
// Assertion macros shared by the checker of the sliding window sender.
// Depends on nothing; each macro expects clk and rst_n in the using scope.
`ifndef SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_FAST_RETRANSMIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, ignored in reset.
`define SWSFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, ignored in reset.
`define SWSFR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/swsfr_pkg.sv
// Shared types and constants of the sliding window sender.
// Used by the top level, its checker and the testbench; depends on no other file.
package swsfr_pkg;

  // Window size must be a power of two of at least 2: the slot is the low sequence bits.
  localparam int WINDOW    = 4;
  localparam int SEQ_BITS  = 8;
  localparam int DATA_BITS = 32;
  localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [SEQ_BITS-1:0] WINDOW_SEQ = SEQ_BITS'(WINDOW);

  // Configuration port.
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_TICKS = 1'd1;

  localparam logic [3:0]  DUP_THRESHOLD_RESET = 4'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;
  localparam logic [3:0]  DUP_MAX             = 4'hF;
  localparam logic [15:0] TIMER_MAX           = 16'hFFFF;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_ACK  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [DATA_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]  ack_number;
    logic                 ack_valid_sum;
  } in_beat_t;

  typedef struct packed {
    logic                 accepted;
    logic                 emit_valid;
    logic [SEQ_BITS-1:0]  emit_seq;
    logic [DATA_BITS-1:0] emit_data;
    logic                 is_resend;
    logic [SEQ_BITS-1:0]  window_base;
    logic [SEQ_BITS-1:0]  next_seq;
    logic                 window_full;
  } out_beat_t;

endpackage

FILE: design/swsfr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the read data holds while no read is issued.
module swsfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sliding_window_sender_fast_retransmit.sv
// Go-back-N sender with fast retransmit.
// Depends on swsfr_pkg and swsfr_ram.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data): one beat per event: a send, an
//   acknowledgement or a timer tick. Every accepted beat yields exactly one
//   result beat on the output channel (out_valid, out_stall, out_data).
// - Configuration (cfg_we, cfg_index, cfg_wdata): index 0 is the duplicate
//   threshold, index 1 the timeout in ticks. Write only while the block is idle.
// - Throughput: one beat per cycle while in_stall is low. Sequence state is
//   updated in the accept cycle, so back-to-back beats see each other's effects.
// - Path: the result of an accepted beat is registered in the read stage (slot RAM
//   read), then in the output buffer, which drives out_valid and out_data.
// - Stall: a two-entry output buffer sits behind the RAM read stage; in_stall
//   rises only when both buffer entries and the read stage hold results.
// - Reset: window base, next sequence, duplicate count and timer clear; the
//   threshold returns to 3 and the timeout to 1000. The slot RAM is not
//   cleared, so a slot must be sent before it can be resent.
module sliding_window_sender_fast_retransmit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  swsfr_pkg::in_beat_t                    in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output swsfr_pkg::out_beat_t                   out_data,
  input  logic                                   cfg_we,
  input  logic [swsfr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [swsfr_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  import swsfr_pkg::*;

  // Sender state.
  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SEQ_BITS-1:0] next_r, next_nxt;
  logic [3:0]          dup_r, dup_nxt;
  logic                run_r, run_nxt;
  logic [15:0]         cnt_r, cnt_nxt;
  logic [3:0]          dup_thr_r;
  logic [15:0]         timeout_r;

  // Event decode.
  logic                in_fire;
  logic                send_ok;
  logic                resend;
  logic [SEQ_BITS-1:0] succ;
  logic [3:0]          dup_inc;
  logic [15:0]         cnt_inc;
  out_beat_t           beat0;

  // Read stage and output buffer.
  logic                 p1_valid_r;
  out_beat_t            p1_beat_r;
  logic                 p1_resend_r;
  logic [DATA_BITS-1:0] ram_rdata;
  out_beat_t            p1_result;
  logic                 push;
  logic                 pop;
  out_beat_t            obuf_r [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           obuf_cnt_r;

  assign in_stall = p1_valid_r && (obuf_cnt_r == 2'd2);
  assign in_fire  = in_valid && !in_stall;

  assign succ    = in_data.ack_number + SEQ_BITS'(1);
  assign dup_inc = (dup_r == DUP_MAX) ? DUP_MAX : dup_r + 4'd1;
  assign cnt_inc = (cnt_r == TIMER_MAX) ? TIMER_MAX : cnt_r + 16'd1;

  // Next state and result fields of one event.
  always_comb begin
    base_nxt = base_r;
    next_nxt = next_r;
    dup_nxt  = dup_r;
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    send_ok  = 1'b0;
    resend   = 1'b0;
    case (in_data.op)
      OP_SEND: begin
        if (SEQ_BITS'(base_r + WINDOW_SEQ) != next_r) begin
          send_ok  = 1'b1;
          next_nxt = next_r + SEQ_BITS'(1);
          if (base_r == next_r) begin
            run_nxt = 1'b1;
            cnt_nxt = 16'd0;
          end
        end
      end
      OP_ACK: begin
        if (in_data.ack_valid_sum) begin
          if (base_r != succ) begin
            // New acknowledgement: slide the window and rearm if data is left.
            dup_nxt  = 4'd0;
            base_nxt = succ;
            run_nxt  = (succ != next_r);
            cnt_nxt  = 16'd0;
          end else if (dup_inc >= dup_thr_r) begin
            resend  = 1'b1;
            run_nxt = 1'b1;
            cnt_nxt = 16'd0;
            dup_nxt = 4'd0;
          end else begin
            dup_nxt = dup_inc;
          end
        end
      end
      OP_TICK: begin
        if (run_r) begin
          if (cnt_inc >= timeout_r) begin
            resend  = 1'b1;
            cnt_nxt = 16'd0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      default: begin
      end
    endcase

    beat0             = '0;
    beat0.accepted    = send_ok;
    beat0.emit_valid  = send_ok || resend;
    beat0.is_resend   = resend;
    beat0.window_base = base_nxt;
    beat0.next_seq    = next_nxt;
    beat0.window_full = (SEQ_BITS'(base_nxt + WINDOW_SEQ) == next_nxt);
    if (send_ok) begin
      beat0.emit_seq  = next_r;
      beat0.emit_data = in_data.payload;
    end else if (resend) begin
      beat0.emit_seq  = base_r;
    end
  end

  // Slot store: a send writes its slot, a retransmission reads the base slot.
  swsfr_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (in_fire && send_ok),
    .waddr (next_r[SLOT_BITS-1:0]),
    .wdata (in_data.payload),
    .re    (in_fire && resend),
    .raddr (base_r[SLOT_BITS-1:0]),
    .rdata (ram_rdata)
  );

  // Merge the RAM data into a retransmission result.
  always_comb begin
    p1_result = p1_beat_r;
    if (p1_resend_r) begin
      p1_result.emit_data = ram_rdata;
    end
  end

  assign out_valid = (obuf_cnt_r != 2'd0);
  assign out_data  = obuf_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push      = p1_valid_r && ((obuf_cnt_r != 2'd2) || pop);

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      next_r     <= '0;
      dup_r      <= '0;
      run_r      <= 1'b0;
      cnt_r      <= '0;
      dup_thr_r  <= DUP_THRESHOLD_RESET;
      timeout_r  <= TIMEOUT_TICKS_RESET;
      p1_valid_r <= 1'b0;
      wr_ptr_r   <= 1'b0;
      rd_ptr_r   <= 1'b0;
      obuf_cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        dup_r  <= dup_nxt;
        run_r  <= run_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DUP_THRESHOLD: dup_thr_r <= cfg_wdata[3:0];
          CFG_TIMEOUT_TICKS: timeout_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      p1_valid_r <= in_fire || (p1_valid_r && !push);
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      obuf_cnt_r <= obuf_cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Payload registers of the read stage and the output buffer.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_beat_r   <= beat0;
      p1_resend_r <= resend;
    end
    if (push) begin
      obuf_r[wr_ptr_r] <= p1_result;
    end
  end

endmodule

FILE: design/swsfr_checker.sv
// Port-level checker for the sliding window sender, bound to the top level.
// Depends on swsfr_pkg and the assertion macros of the defines header.
`include "sliding_window_sender_fast_retransmit_defines.svh"

module swsfr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input swsfr_pkg::in_beat_t                 in_data,
  input logic                                out_valid,
  input logic                                out_stall,
  input swsfr_pkg::out_beat_t                out_data
);

  import swsfr_pkg::*;

  // A taken send is always emitted as a first transmission.
  `SWSFR_ASSERT_IMP(a_accept_emits, out_valid && out_data.accepted, out_data.emit_valid && !out_data.is_resend, "accepted send not emitted as new packet")

  // Without an emitted packet the packet fields stay zero.
  `SWSFR_ASSERT_IMP(a_idle_fields, out_valid && !out_data.emit_valid, (out_data.emit_seq == '0) && (out_data.emit_data == '0) && !out_data.is_resend, "packet fields set without emit")

  // The full flag agrees with the reported base and next sequence.
  `SWSFR_ASSERT_IMP(a_full_flag, out_valid, out_data.window_full == (SEQ_BITS'(out_data.window_base + WINDOW_SEQ) == out_data.next_seq), "window_full disagrees with base and next_seq")

  // A stalled result beat holds.
  `SWSFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

  // A stalled input beat holds until it is taken.
  `SWSFR_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled input beat changed")

endmodule

bind sliding_window_sender_fast_retransmit swsfr_checker u_swsfr_checker (.*);

FILE: tb/sliding_window_sender_fast_retransmit_test.sv
// Self-checking bench for the go-back-N sender with fast retransmit.
// A directed table runs first, then random traffic under several register settings.
// Depends on swsfr_pkg and the sliding_window_sender_fast_retransmit top level.
`timescale 1ns / 100ps

module sliding_window_sender_fast_retransmit_test;
  import swsfr_pkg::*;

  // The unused operation code: the block must ignore it.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int STUCK_LIMIT = 1000;
  localparam int PHASE_EVENTS = 70;

  typedef enum int {EV_SEND, EV_ACK_NEW, EV_ACK_DUP, EV_TICK, EV_NOISE} traffic_t;

  typedef struct {
    bit                        is_cfg;
    logic [CFG_IDX_BITS-1:0]   reg_idx;
    logic [CFG_DATA_BITS-1:0]  reg_val;
    in_beat_t                  beat;
    bit                        has_want;
    out_beat_t                 want;
  } plan_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_beat_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_beat_t                 out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // Mirror of the sender state and its two registers.
  logic [DATA_BITS-1:0] w_slots [WINDOW];
  bit                   w_written [WINDOW];
  logic [SEQ_BITS-1:0]  w_base = '0;
  logic [SEQ_BITS-1:0]  w_next = '0;
  logic [3:0]           w_dups = '0;
  bit                   w_timer_on = 1'b0;
  logic [15:0]          w_ticks = '0;
  logic [3:0]           w_thr = DUP_THRESHOLD_RESET;
  logic [15:0]          w_timeout = TIMEOUT_TICKS_RESET;

  out_beat_t status_q[$];
  plan_row_t plan[$];

  bit calm = 1'b0;
  int mismatches = 0;
  int events_sent = 0;
  int results_seen = 0;
  int resends = 0;
  int refused = 0;
  int settings_run = 1;
  int stall_cycles = 0;
  int idle_cycles = 0;

  int unsigned thr_set[6]     = '{2, 0, 15, 1, 3, 6};
  int unsigned timeout_set[6] = '{8, 0, 1, 30, 1000, 3};

  sliding_window_sender_fast_retransmit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit window_full_now();
    return (w_base + WINDOW_SEQ) == w_next;
  endfunction

  // Applies one event to the mirrored state and returns the status beat it yields.
  function automatic out_beat_t sender_step(in_beat_t b);
    out_beat_t r;
    logic [SEQ_BITS-1:0] succ;
    bit resend;
    r = '0;
    resend = 1'b0;
    succ = b.ack_number + 8'd1;
    case (b.op)
      OP_SEND: begin
        if (!window_full_now()) begin
          w_slots[w_next[SLOT_BITS-1:0]] = b.payload;
          w_written[w_next[SLOT_BITS-1:0]] = 1'b1;
          r.accepted = 1'b1;
          r.emit_valid = 1'b1;
          r.emit_seq = w_next;
          r.emit_data = b.payload;
          if (w_base == w_next) begin
            w_timer_on = 1'b1;
            w_ticks = '0;
          end
          w_next = w_next + 8'd1;
        end
      end
      OP_ACK: begin
        if (b.ack_valid_sum) begin
          if (w_base != succ) begin
            // A new number moves the base; the timer runs only while data is outstanding.
            w_dups = '0;
            w_base = succ;
            w_timer_on = (w_base != w_next);
            w_ticks = '0;
          end else begin
            if (w_dups != DUP_MAX) w_dups = w_dups + 4'd1;
            if (w_dups >= w_thr) begin
              resend = 1'b1;
              w_timer_on = 1'b1;
              w_ticks = '0;
              w_dups = '0;
            end
          end
        end
      end
      OP_TICK: begin
        if (w_timer_on) begin
          if (w_ticks != TIMER_MAX) w_ticks = w_ticks + 16'd1;
          if (w_ticks >= w_timeout) begin
            resend = 1'b1;
            w_ticks = '0;
          end
        end
      end
      default: ;
    endcase
    if (resend) begin
      r.emit_valid = 1'b1;
      r.is_resend = 1'b1;
      r.emit_seq = w_base;
      r.emit_data = w_slots[w_base[SLOT_BITS-1:0]];
    end
    r.window_base = w_base;
    r.next_seq = w_next;
    r.window_full = window_full_now();
    return r;
  endfunction

  // True when the event would retransmit a slot that no send has filled yet.
  function automatic bit reads_blank_slot(in_beat_t b);
    logic [SEQ_BITS-1:0] succ;
    logic [3:0] dups;
    logic [15:0] ticks;
    succ = b.ack_number + 8'd1;
    if (w_written[w_base[SLOT_BITS-1:0]]) return 1'b0;
    if (b.op == OP_ACK && b.ack_valid_sum && succ == w_base) begin
      dups = (w_dups == DUP_MAX) ? w_dups : w_dups + 4'd1;
      return dups >= w_thr;
    end
    if (b.op == OP_TICK && w_timer_on) begin
      ticks = (w_ticks == TIMER_MAX) ? w_ticks : w_ticks + 16'd1;
      return ticks >= w_timeout;
    end
    return 1'b0;
  endfunction

  function automatic in_beat_t mk_beat(logic [1:0] op, logic [31:0] payload,
                                       logic [7:0] ack, logic sum_ok);
    in_beat_t b;
    b.op = op;
    b.payload = payload;
    b.ack_number = ack;
    b.ack_valid_sum = sum_ok;
    return b;
  endfunction

  function automatic out_beat_t mk_status(int acc, int ev, int seq,
                                          logic [31:0] data, int rs, int base,
                                          int nxt, int full);
    out_beat_t s;
    s.accepted = 1'(acc);
    s.emit_valid = 1'(ev);
    s.emit_seq = SEQ_BITS'(seq);
    s.emit_data = data;
    s.is_resend = 1'(rs);
    s.window_base = SEQ_BITS'(base);
    s.next_seq = SEQ_BITS'(nxt);
    s.window_full = 1'(full);
    return s;
  endfunction

  function automatic plan_row_t ev_row(in_beat_t b);
    plan_row_t p;
    p = '{default: '0};
    p.beat = b;
    return p;
  endfunction

  function automatic plan_row_t ev_row_w(in_beat_t b, out_beat_t w);
    plan_row_t p;
    p = ev_row(b);
    p.has_want = 1'b1;
    p.want = w;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx,
                                        logic [CFG_DATA_BITS-1:0] val);
    plan_row_t p;
    p = '{default: '0};
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  // Builds a well-formed event of the given kind, or noise.
  function automatic in_beat_t gen_beat(traffic_t kind);
    in_beat_t b;
    logic [SEQ_BITS-1:0] span;
    b = mk_beat(OP_SEND, $urandom(), 8'($urandom()), 1'b1);
    span = w_next - w_base;
    case (kind)
      EV_SEND: b.op = OP_SEND;
      EV_ACK_NEW: begin
        b.op = OP_ACK;
        if (span == 0) b.ack_number = w_base - 8'd1;
        else b.ack_number = w_base - 8'd1 + 8'($urandom_range(1, span));
      end
      EV_ACK_DUP: begin
        b.op = OP_ACK;
        b.ack_number = w_base - 8'd1;
      end
      EV_TICK: b.op = OP_TICK;
      default: begin
        b.op = 2'($urandom_range(0, 3));
        b.ack_valid_sum = 1'($urandom());
      end
    endcase
    if (reads_blank_slot(b)) b.op = OP_SEND;
    return b;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic cmp(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
  endtask

  // Predicts the event, then offers it as one input beat and waits for acceptance.
  task automatic drive_event(input in_beat_t b, input bit has_want, input out_beat_t want);
    out_beat_t predicted;
    int gap;
    predicted = sender_step(b);
    if (predicted.is_resend) resends++;
    if (b.op == OP_SEND && !predicted.accepted) refused++;
    status_q.push_back(has_want ? want : predicted);
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    events_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DUP_THRESHOLD) w_thr = val[3:0];
    else w_timeout = val;
  endtask

  task automatic run_random(input int wanted);
    int done_n;
    int pick;
    int reps;
    traffic_t kind;
    out_beat_t unused;
    done_n = 0;
    unused = '0;
    while (done_n < wanted) begin
      calm = ($urandom_range(0, 4) == 0);
      // Now and then hold off until everything in flight has come back.
      if ($urandom_range(0, 39) == 0) drain();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        kind = EV_SEND;
        reps = $urandom_range(1, 6);
      end else if (pick < 48) begin
        kind = EV_ACK_NEW;
        reps = $urandom_range(1, 2);
      end else if (pick < 63) begin
        kind = EV_ACK_DUP;
        reps = $urandom_range(1, w_thr + 2);
      end else if (pick < 85) begin
        kind = EV_TICK;
        reps = $urandom_range(1, (w_timeout < 30) ? w_timeout + 2 : 30);
      end else begin
        kind = EV_NOISE;
        reps = $urandom_range(1, 3);
      end
      for (int i = 0; i < reps; i++) begin
        drive_event(gen_beat(kind), 1'b0, unused);
        done_n++;
      end
    end
  endtask

  task automatic build_plan();
    // Quiet events right after reset: nothing moves.
    plan.push_back(ev_row_w(mk_beat(OP_TICK, 32'h0, 8'h00, 1'b0),
                            mk_status(0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_IDLE, 32'h8000_0001, 8'hFF, 1'b1),
                            mk_status(0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'h5A, 1'b0),
                            mk_status(0, 0, 0, 0, 0, 0, 0, 0)));
    // Fill the window, then one send is refused.
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'hFFFF_FFFF, 8'h00, 1'b0),
                            mk_status(1, 1, 0, 32'hFFFF_FFFF, 0, 0, 1, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'h0, 8'hFF, 1'b1),
                            mk_status(1, 1, 1, 32'h0, 0, 0, 2, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'hA5A5_5A5A, 8'h00, 1'b0),
                            mk_status(1, 1, 2, 32'hA5A5_5A5A, 0, 0, 3, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'h1234_5678, 8'h00, 1'b0),
                            mk_status(1, 1, 3, 32'h1234_5678, 0, 0, 4, 1)));
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'hDEAD_BEEF, 8'h00, 1'b0),
                            mk_status(0, 0, 0, 0, 0, 0, 4, 1)));
    // Three duplicates of the number before the base trigger a fast retransmit.
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'hFF, 1'b1),
                            mk_status(0, 0, 0, 0, 0, 0, 4, 1)));
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'hFF, 1'b1),
                            mk_status(0, 0, 0, 0, 0, 0, 4, 1)));
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'hFF, 1'b1),
                            mk_status(0, 1, 0, 32'hFFFF_FFFF, 1, 0, 4, 1)));
    // Acknowledge everything; the timer stops and ticks do nothing.
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'h00, 1'b1),
                            mk_status(0, 0, 0, 0, 0, 1, 4, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'h03, 1'b1),
                            mk_status(0, 0, 0, 0, 0, 4, 4, 0)));
    plan.push_back(ev_row_w(mk_beat(OP_TICK, 32'h0, 8'h00, 1'b0),
                            mk_status(0, 0, 0, 0, 0, 4, 4, 0)));
    // A zero threshold resends the base even with an empty window.
    plan.push_back(cfg_row(CFG_DUP_THRESHOLD, 16'd0));
    plan.push_back(ev_row_w(mk_beat(OP_ACK, 32'h0, 8'h03, 1'b1),
                            mk_status(0, 1, 4, 32'hFFFF_FFFF, 1, 4, 4, 0)));
    // A zero timeout expires on every running tick.
    plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 16'd0));
    plan.push_back(ev_row_w(mk_beat(OP_TICK, 32'h0, 8'h00, 1'b0),
                            mk_status(0, 1, 4, 32'hFFFF_FFFF, 1, 4, 4, 0)));
    plan.push_back(cfg_row(CFG_DUP_THRESHOLD, 16'd15));
    plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 16'd2));
    // A send at the base restarts the timer, which then expires after two ticks.
    plan.push_back(ev_row_w(mk_beat(OP_SEND, 32'h0F0F_0F0F, 8'h00, 1'b0),
                            mk_status(1, 1, 4, 32'h0F0F_0F0F, 0, 4, 5, 0)));
    plan.push_back(ev_row(mk_beat(OP_TICK, 32'h0, 8'h00, 1'b0)));
    plan.push_back(ev_row(mk_beat(OP_TICK, 32'h0, 8'h00, 1'b0)));
    // Acknowledgements outside the window still move the base.
    plan.push_back(ev_row(mk_beat(OP_ACK, 32'h5555_AAAA, 8'hC8, 1'b1)));
    plan.push_back(ev_row(mk_beat(OP_ACK, 32'h0, 8'hFF, 1'b1)));
    plan.push_back(ev_row(mk_beat(OP_ACK, 32'h0, 8'h7F, 1'b0)));
  endtask

  // Result side: random stall per beat, field-by-field check against the oldest entry.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_q.size() == 0) begin
          report("result beat with no event outstanding");
        end else begin
          want = status_q.pop_front();
          cmp("accepted", 32'(out_data.accepted), 32'(want.accepted));
          cmp("emit_valid", 32'(out_data.emit_valid), 32'(want.emit_valid));
          cmp("emit_seq", 32'(out_data.emit_seq), 32'(want.emit_seq));
          cmp("emit_data", out_data.emit_data, want.emit_data);
          cmp("is_resend", 32'(out_data.is_resend), 32'(want.is_resend));
          cmp("window_base", 32'(out_data.window_base), 32'(want.window_base));
          cmp("next_seq", 32'(out_data.next_seq), 32'(want.next_seq));
          cmp("window_full", 32'(out_data.window_full), 32'(want.window_full));
        end
        stall_cycles = calm ? 0 : $urandom_range(0, 6);
      end else if (stall_cycles > 0) begin
        stall_cycles--;
      end
      out_stall <= (stall_cycles != 0);
    end
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
        $display("[sliding_window_sender_fast_retransmit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    out_beat_t unused;
    logic [SEQ_BITS-1:0] jump;
    unused = '0;
    for (int s = 0; s < WINDOW; s++) begin
      w_slots[s] = '0;
      w_written[s] = 1'b0;
    end
    build_plan();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        drive_event(plan[i].beat, plan[i].has_want, plan[i].want);
      end
    end

    // Random traffic under several register settings.
    foreach (thr_set[p]) begin
      write_reg(CFG_DUP_THRESHOLD, 16'(thr_set[p]));
      write_reg(CFG_TIMEOUT_TICKS, 16'(timeout_set[p]));
      settings_run++;
      run_random(PHASE_EVENTS);
    end

    // Largest timeout: restart the timer with a jump of the base; a few ticks stay short of it.
    write_reg(CFG_DUP_THRESHOLD, 16'd12);
    write_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
    settings_run++;
    calm = 1'b1;
    jump = w_next + 8'd100;
    if (jump + 8'd1 == w_base) jump = jump + 8'd1;
    drive_event(mk_beat(OP_ACK, $urandom(), jump, 1'b1), 1'b0, unused);
    repeat (3) drive_event(gen_beat(EV_TICK), 1'b0, unused);
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) report($sformatf("%0d results never arrived", status_q.size()));
    $display("covered %0d events and %0d results under %0d register settings",
             events_sent, results_seen, settings_run);
    $display("  including %0d retransmissions and %0d sends refused on a full window",
             resends, refused);
    if (mismatches == 0) begin
      $display("[sliding_window_sender_fast_retransmit] OK");
    end else begin
      $display("[sliding_window_sender_fast_retransmit] ERROR");
    end
    $finish;
  end

endmodule
